// ----- src/wsfu_pkg.sv -----
// Package for the WebSocket frame unmasker: payload structs, request and
// result codes, header byte values and parser phase encoding.
// No dependencies.
`timescale 1ns / 1ps

package wsfu_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_RX_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_OPEN    = 2'd2;

  // Result codes
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_EMPTY   = 3'd1;
  localparam logic [2:0] KIND_PING    = 3'd2;
  localparam logic [2:0] KIND_CLOSE   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // Accepted frame header bytes (FIN set)
  localparam logic [7:0] HDR_TEXT  = 8'h81;
  localparam logic [7:0] HDR_PONG  = 8'h8A;
  localparam logic [7:0] HDR_CLOSE = 8'h88;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PING_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PONG_MARGIN   = 1'd1;

  localparam logic [15:0] PONG_MARGIN_RST = 16'd500;

  // Result queue geometry
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 3;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_MASK = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] data_byte;
    logic       last_flag;
  } out_item_t;

endpackage

// ----- src/websocket_frame_unmasker.sv -----
// Top level of the WebSocket frame unmasker: frame parser, payload unmask,
// keepalive timers and a small result queue.
// Depends on wsfu_pkg.
`timescale 1ns / 1ps

// One request is taken per clock: a received byte, a millisecond tick or a
// connection-open event. Each request is parsed and its results written into a
// four-entry result queue on the edge that accepts it, and out_valid follows
// from the registered queue count. A request gives at most two results (a
// tick can give a ping request and a timeout), so in_ready drops whenever
// fewer than two queue slots are free; with out_ready held high the block
// sustains one request per cycle. Configuration writes are taken at any time
// (cfg_ready is tied high) and should only be issued while the block is idle.
module websocket_frame_unmasker
  import wsfu_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  // Configuration registers
  logic [15:0] ping_interval_r;
  logic [15:0] pong_margin_r;

  // Parser and timer state
  phase_t                phase_r, phase_nxt;
  logic                  is_close_r, is_close_nxt;
  logic [6:0]            remain_r, remain_nxt;
  logic [1:0]            mask_pos_r, mask_pos_nxt;
  logic [7:0]            mask_key_r [4];
  logic                  mask_wr;
  logic [TIMER_BITS-1:0] ping_elapsed_r, ping_elapsed_nxt;
  logic [TIMER_BITS-1:0] pong_elapsed_r, pong_elapsed_nxt;
  logic                  link_open_r, link_open_nxt;

  // Result queue
  out_item_t             oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_wr_ptr_r, oq_rd_ptr_r;
  logic [OQ_CNT_W-1:0]   oq_cnt_r;

  // Request decode
  logic                  in_fire;
  logic                  out_fire;
  logic                  push0, push1;
  out_item_t             res0, res1;
  logic [7:0]            unmasked;
  logic [TIMER_BITS-1:0] ping_inc, pong_inc;
  logic [16:0]           pong_limit;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = oq_cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign cfg_ready = 1'b1;

  assign unmasked   = in_data.rx_byte ^ mask_key_r[mask_pos_r];
  assign pong_limit = {1'b0, ping_interval_r} + {1'b0, pong_margin_r};
  assign ping_inc   = (ping_elapsed_r == '1) ? ping_elapsed_r
                                             : ping_elapsed_r + TIMER_BITS'(1);
  assign pong_inc   = (pong_elapsed_r == '1) ? pong_elapsed_r
                                             : pong_elapsed_r + TIMER_BITS'(1);

  // Next-state and result logic for one request
  always_comb begin
    phase_nxt        = phase_r;
    is_close_nxt     = is_close_r;
    remain_nxt       = remain_r;
    mask_pos_nxt     = mask_pos_r;
    mask_wr          = 1'b0;
    ping_elapsed_nxt = ping_elapsed_r;
    pong_elapsed_nxt = pong_elapsed_r;
    link_open_nxt    = link_open_r;
    push0            = 1'b0;
    push1            = 1'b0;
    res0             = '0;
    res1             = '0;

    case (in_data.req_type)
      REQ_RX_BYTE: begin
        case (phase_r)
          PH_IDLE: begin
            if (in_data.rx_byte == HDR_TEXT) begin
              ping_elapsed_nxt = '0;
              pong_elapsed_nxt = '0;
              is_close_nxt     = 1'b0;
              phase_nxt        = PH_LEN;
            end else if (in_data.rx_byte == HDR_PONG) begin
              pong_elapsed_nxt = '0;
              is_close_nxt     = 1'b0;
              phase_nxt        = PH_LEN;
            end else if (in_data.rx_byte == HDR_CLOSE) begin
              is_close_nxt = 1'b1;
              phase_nxt    = PH_LEN;
            end
          end
          PH_LEN: begin
            remain_nxt   = in_data.rx_byte[6:0];
            mask_pos_nxt = 2'd0;
            phase_nxt    = PH_MASK;
          end
          PH_MASK: begin
            mask_wr      = 1'b1;
            mask_pos_nxt = mask_pos_r + 2'd1;
            if (mask_pos_r == 2'd3) begin
              if (remain_r != 7'd0) begin
                phase_nxt = PH_DATA;
              end else if (is_close_r) begin
                // empty close frame: reply at once
                phase_nxt         = PH_IDLE;
                link_open_nxt     = 1'b0;
                is_close_nxt      = 1'b0;
                push0             = 1'b1;
                res0.result_kind  = KIND_CLOSE;
              end else begin
                phase_nxt         = PH_IDLE;
                push0             = 1'b1;
                res0.result_kind  = KIND_EMPTY;
                res0.last_flag    = 1'b1;
              end
            end
          end
          PH_DATA: begin
            mask_pos_nxt = mask_pos_r + 2'd1;
            remain_nxt   = remain_r - 7'd1;
            if (is_close_r) begin
              // close payload is dropped; reply after its last byte
              if (remain_r == 7'd1) begin
                phase_nxt        = PH_IDLE;
                link_open_nxt    = 1'b0;
                is_close_nxt     = 1'b0;
                push0            = 1'b1;
                res0.result_kind = KIND_CLOSE;
              end
            end else begin
              push0            = 1'b1;
              res0.result_kind = KIND_BYTE;
              res0.data_byte   = unmasked;
              res0.last_flag   = (remain_r == 7'd1);
              if (remain_r == 7'd1) begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      REQ_TICK: begin
        if (link_open_r) begin
          ping_elapsed_nxt = ping_inc;
          pong_elapsed_nxt = pong_inc;
          if (ping_interval_r != 16'd0) begin
            if (ping_inc > TIMER_BITS'(ping_interval_r)) begin
              ping_elapsed_nxt = '0;
              push0            = 1'b1;
              res0.result_kind = KIND_PING;
            end
            if (pong_inc > TIMER_BITS'(pong_limit)) begin
              link_open_nxt = 1'b0;
              phase_nxt     = PH_IDLE;
              is_close_nxt  = 1'b0;
              remain_nxt    = 7'd0;
              mask_pos_nxt  = 2'd0;
              // timeout follows the ping request when both fire
              if (push0) begin
                push1            = 1'b1;
                res1.result_kind = KIND_TIMEOUT;
              end else begin
                push0            = 1'b1;
                res0.result_kind = KIND_TIMEOUT;
              end
            end
          end
        end
      end
      REQ_OPEN: begin
        link_open_nxt    = 1'b1;
        ping_elapsed_nxt = '0;
        pong_elapsed_nxt = '0;
        phase_nxt        = PH_IDLE;
        is_close_nxt     = 1'b0;
        remain_nxt       = 7'd0;
        mask_pos_nxt     = 2'd0;
      end
      default: begin
        // reserved request code: no effect
      end
    endcase
  end

  // Parser and timer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      is_close_r     <= 1'b0;
      remain_r       <= 7'd0;
      mask_pos_r     <= 2'd0;
      ping_elapsed_r <= '0;
      pong_elapsed_r <= '0;
      link_open_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      is_close_r     <= is_close_nxt;
      remain_r       <= remain_nxt;
      mask_pos_r     <= mask_pos_nxt;
      ping_elapsed_r <= ping_elapsed_nxt;
      pong_elapsed_r <= pong_elapsed_nxt;
      link_open_r    <= link_open_nxt;
    end
  end

  // Mask key, written by the four mask bytes of each frame
  always_ff @(posedge clk) begin
    if (in_fire && mask_wr) begin
      mask_key_r[mask_pos_r] <= in_data.rx_byte;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_interval_r <= 16'd0;
      pong_margin_r   <= PONG_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PING_INTERVAL: ping_interval_r <= cfg_wdata;
        REG_PONG_MARGIN:   pong_margin_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result queue: up to two writes and one read per cycle
  always_ff @(posedge clk) begin
    if (in_fire && push0) begin
      oq_r[oq_wr_ptr_r] <= res0;
    end
    if (in_fire && push1) begin
      oq_r[oq_wr_ptr_r + OQ_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      oq_wr_ptr_r <= oq_wr_ptr_r + OQ_PTR_W'(in_fire && push0)
                                 + OQ_PTR_W'(in_fire && push1);
      oq_rd_ptr_r <= oq_rd_ptr_r + OQ_PTR_W'(out_fire);
      oq_cnt_r    <= oq_cnt_r + OQ_CNT_W'(in_fire && push0)
                              + OQ_CNT_W'(in_fire && push1)
                              - OQ_CNT_W'(out_fire);
    end
  end

  assign out_valid = (oq_cnt_r != '0);
  assign out_data  = oq_r[oq_rd_ptr_r];

  // Checks
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0)
    else $error("second result without a first");

  a_tick_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == REQ_TICK && !link_open_r) |-> !push0)
    else $error("result from a tick while link closed");

  a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == REQ_OPEN) |=>
      (link_open_r && ping_elapsed_r == '0 && pong_elapsed_r == '0 &&
       phase_r == PH_IDLE))
    else $error("open request did not reset link state");

endmodule
